>>> rtl/integer_row_tokenizer_assert.svh
// Assertion macros used by the tokenizer top level.
`ifndef INTEGER_ROW_TOKENIZER_ASSERT_SVH
`define INTEGER_ROW_TOKENIZER_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define IRT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define IRT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/irt_pkg.sv
package irt_pkg;

    localparam int CHAR_W   = 8;
    localparam int VALUE_W  = 32;
    localparam int COLUMN_W = 10;
    localparam int WIDTH_W  = 11;
    localparam int PHASE_W  = 2;
    localparam int TDATA_W  = 48;

    localparam logic [WIDTH_W-1:0] ROW_WIDTH_RESET = 11'd1024;

    localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_PREFIX = 2'd1;
    localparam logic [PHASE_W-1:0] PH_NUMBER = 2'd2;
    localparam logic [PHASE_W-1:0] PH_SKIP   = 2'd3;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'd43;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              end_of_line;
    } beat_t;

    typedef struct packed {
        logic                valid;
        logic                has_value;
        logic                last_of_line;
        logic [VALUE_W-1:0]  value;
        logic [COLUMN_W-1:0] column;
    } result_t;

endpackage

>>> rtl/irt_in_stage.sv
module irt_in_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  irt_pkg::beat_t s_beat,
    input  logic          advance,
    output logic          in_valid,
    output irt_pkg::beat_t in_beat
);
    import irt_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    beat_t beat_reg;

    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            beat_reg <= s_beat;
        end
    end

    assign in_valid = valid_reg;
    assign in_beat  = beat_reg;

endmodule

>>> rtl/irt_parser.sv
module irt_parser #(
    parameter int MAX_COLUMNS = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  irt_pkg::beat_t                beat,
    input  logic [irt_pkg::WIDTH_W-1:0]   row_width,
    output irt_pkg::result_t              result
);
    import irt_pkg::*;

    localparam int CNT_W = $clog2(MAX_COLUMNS + 1);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic               neg_reg, neg_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic [CHAR_W-1:0]  c;
    logic               sep, digit, ctrl, sign;
    logic [PHASE_W-1:0] tok_phase;
    logic [VALUE_W-1:0] tok_acc;
    logic               tok_neg;
    logic [VALUE_W-1:0] digit_val;
    logic [VALUE_W-1:0] limit;
    logic               done, emit;

    assign c         = beat.char_code;
    assign sep       = (c == CH_SPACE) || (c == CH_TAB);
    assign digit     = (c >= CH_ZERO) && (c <= CH_NINE);
    assign ctrl      = (c >= CH_LF) && (c <= CH_CR);
    assign sign      = (c == CH_PLUS) || (c == CH_MINUS);
    assign digit_val = VALUE_W'(c - CH_ZERO);

    always_comb begin
        tok_phase = phase_reg;
        tok_acc   = acc_reg;
        tok_neg   = neg_reg;
        if (!sep) begin
            if (phase_reg == PH_IDLE || phase_reg == PH_PREFIX) begin
                if (ctrl) begin
                    tok_phase = PH_PREFIX;
                end else if (sign) begin
                    tok_neg   = (c == CH_MINUS);
                    tok_phase = PH_NUMBER;
                end else if (digit) begin
                    tok_acc   = digit_val;
                    tok_phase = PH_NUMBER;
                end else begin
                    tok_phase = PH_SKIP;
                end
            end else if (phase_reg == PH_NUMBER) begin
                if (digit) begin
                    tok_acc = (acc_reg << 3) + (acc_reg << 1) + digit_val;
                end else begin
                    tok_phase = PH_SKIP;
                end
            end
        end
    end

    assign limit = (VALUE_W'(row_width) < VALUE_W'(MAX_COLUMNS)) ?
                   VALUE_W'(row_width) : VALUE_W'(MAX_COLUMNS);
    assign done  = sep ? (phase_reg != PH_IDLE)
                       : (beat.end_of_line &&
                          (tok_phase == PH_NUMBER || tok_phase == PH_SKIP));
    assign emit  = done && (VALUE_W'(cnt_reg) < limit);

    always_comb begin
        result.valid        = emit || beat.end_of_line;
        result.has_value    = emit;
        result.last_of_line = beat.end_of_line;
        result.value        = '0;
        result.column       = '0;
        if (emit) begin
            result.value  = tok_neg ? (VALUE_W'(0) - tok_acc) : tok_acc;
            result.column = COLUMN_W'(VALUE_W'(cnt_reg));
        end
    end

    always_comb begin
        phase_next = tok_phase;
        acc_next   = tok_acc;
        neg_next   = tok_neg;
        cnt_next   = cnt_reg;
        if (sep || beat.end_of_line) begin
            phase_next = PH_IDLE;
            acc_next   = '0;
            neg_next   = 1'b0;
        end
        if (beat.end_of_line) begin
            cnt_next = '0;
        end else if (emit) begin
            cnt_next = CNT_W'(cnt_reg + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            cnt_reg   <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

>>> rtl/irt_out_stage.sv
module irt_out_stage (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         load,
    input  irt_pkg::result_t             result,
    output logic                         out_free,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [irt_pkg::TDATA_W-1:0]  m_tdata,
    output logic                         m_tuser,
    output logic                         m_tlast
);
    import irt_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign out_free   = !valid_reg || m_tready;
    assign valid_next = out_free ? (load && result.valid) : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && load && result.valid) begin
            res_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {(TDATA_W - VALUE_W - COLUMN_W)'(0), res_reg.column, res_reg.value};
    assign m_tuser  = res_reg.has_value;
    assign m_tlast  = res_reg.last_of_line;

endmodule

>>> rtl/integer_row_tokenizer.sv
// Integer row tokenizer: parses whitespace-separated decimal integers from a text line.
// Input stream: one byte per beat in s_tdata[7:0], s_tlast on the line's last byte.
// Output stream: one beat per kept token or line end, m_tdata[31:0] is the signed value,
// m_tdata[41:32] its column in the line, m_tuser is set when the beat carries a value
// and m_tlast marks the beat caused by the line's last byte (which always yields one).
// The cfg channel writes row_width, the number of values kept per line (at most
// MAX_COLUMNS); it should be written only while the block is idle.
// Order: an accepted beat waits in the input register, and its result enters the result
// register once that register is free to load.
// Throughput: one input beat per cycle unless the receiver stalls; the per-byte
// state update (multiply by ten and add) sits between the input and result registers.
// Reset clears both stage valid flags and the token state, and sets row_width to 1024.
// When the receiver stalls, the result register holds its beat; the input register
// still takes one more beat, then s_tready drops until the result is taken.
`include "integer_row_tokenizer_assert.svh"

module integer_row_tokenizer #(
    parameter int MAX_COLUMNS = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,    // char_code
    input  logic                         s_tlast,    // end_of_line
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [irt_pkg::TDATA_W-1:0]  m_tdata,    // value, column, zero fill
    output logic                         m_tuser,    // has_value
    output logic                         m_tlast,    // last_of_line
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [irt_pkg::WIDTH_W-1:0]  cfg_data
);
    import irt_pkg::*;

    logic [WIDTH_W-1:0] row_width_reg;
    beat_t              s_beat;
    beat_t              in_beat;
    logic               in_valid;
    logic               out_free;
    logic               step;
    result_t            result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg <= ROW_WIDTH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            row_width_reg <= cfg_data;
        end
    end

    assign s_beat.char_code   = s_tdata;
    assign s_beat.end_of_line = s_tlast;
    assign step               = in_valid && out_free;

    irt_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_beat   (s_beat),
        .advance  (out_free),
        .in_valid (in_valid),
        .in_beat  (in_beat)
    );

    irt_parser #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .beat      (in_beat),
        .row_width (row_width_reg),
        .result    (result)
    );

    irt_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step),
        .result   (result),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    `IRT_ASSERT_NOW(a_bare_only_at_eol, aclk, aresetn, m_tvalid && !m_tuser, m_tlast, "Bare beat without line end")
    `IRT_ASSERT_NOW(a_bare_is_zero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata == '0, "Bare beat carries nonzero data")
    `IRT_ASSERT_NOW(a_full_blocks_input, aclk, aresetn, in_valid && m_tvalid && !m_tready, !s_tready, "Input taken while both stages are full")
    `IRT_ASSERT_NEXT(a_eol_gives_result, aclk, aresetn, step && in_beat.end_of_line, m_tvalid && m_tlast, "Line end produced no result")

endmodule
